// ----- rtl/core/lbleq_pkg.sv -----
// ----------------------------------------------------------------------------
// lbleq_pkg
// Shared constants for the label equivalence table: operation codes, status
// codes, item field widths and the default table size.
// ----------------------------------------------------------------------------
package lbleq_pkg;

    // Default number of label entries
    localparam int NUM_LABELS_DEF = 256;

    // Item field widths
    localparam int FUNC_W   = 2;
    localparam int LABEL_W  = 8;
    localparam int CLASS_W  = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;

    // Operation codes
    localparam logic [FUNC_W-1:0] FN_ADD   = 2'd0;
    localparam logic [FUNC_W-1:0] FN_MERGE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_WHICH = 2'd2;
    localparam logic [FUNC_W-1:0] FN_HAS   = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NO_LABEL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BAD_INDEX = 2'd2;

endpackage

// ----- rtl/core/lbleq_ram.sv -----
// ----------------------------------------------------------------------------
// lbleq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lbleq_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/label_equivalence_table.sv -----
// ----------------------------------------------------------------------------
// label_equivalence_table
// Partition of labels into numbered classes with add, merge, which-class and
// has-label-in-class operations.
// ----------------------------------------------------------------------------
// One item is taken at a time. Add, which-class and has read one RAM entry
// (state S_RDA) and give their result through the output register. Merge of
// two distinct labels reads both (S_RDA, S_RDB) and gives its result after
// S_RDB when no sweep is needed. When both are present and their classes
// differ it sweeps the whole label RAM once, one entry per cycle through a
// read-modify-write pipeline (S_SCAN), with DEPTH = min(NUM_LABELS, 256)
// since labels are 8 bits wide. After reset the block runs a clearing pass
// over every entry of the label RAM before it raises s_axis_tready. Labels at
// or above DEPTH are never present. The result waits in an output register,
// so the block takes the next item in the same cycle as the last result is taken.
// ----------------------------------------------------------------------------
module label_equivalence_table #(
    parameter int NUM_LABELS = lbleq_pkg::NUM_LABELS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input items
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [23:0]                    s_axis_tdata,  // value_a, value_b, class_index
    input  logic [lbleq_pkg::FUNC_W-1:0]   s_axis_tuser,  // func
    // Result items
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [23:0]                    m_axis_tdata   // class_found, found, status,
                                                          // class_count, zero pad
);
    import lbleq_pkg::*;

    // Table geometry
    localparam int DEPTH  = (NUM_LABELS < 256) ? NUM_LABELS : 256;
    localparam int AW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH);
    localparam int NW     = $clog2(DEPTH + 1);
    localparam int EW     = CW + 1;
    localparam logic [LABEL_W:0] DEPTH_V = (LABEL_W + 1)'(DEPTH);
    localparam logic [AW-1:0]    LAST    = AW'(DEPTH - 1);

    // Sequencer states
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RDA   = 3'd2;
    localparam logic [2:0] S_RDB   = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_addr, n_addr;
    logic [NW-1:0] r_num, n_num;
    logic [EW-1:0] r_ent_a, n_ent_a;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_hi, n_hi;

    // Latched item
    logic [FUNC_W-1:0]  r_func;
    logic [LABEL_W-1:0] r_va, r_vb, r_ci;
    logic               r_a_ok, r_b_ok;

    // Output register
    logic                r_ovalid;
    logic [CLASS_W-1:0]  r_ocls;
    logic                r_ofound;
    logic [STATUS_W-1:0] r_ostat;
    logic [COUNT_W-1:0]  r_ocount;

    // Result of the finishing cycle
    logic                done;
    logic [CLASS_W-1:0]  d_cls;
    logic                d_found;
    logic [STATUS_W-1:0] d_stat;

    // RAM port
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;

    logic               accept;
    logic [LABEL_W-1:0] in_va, in_vb, in_ci;
    logic               rd_valid;
    logic [CW-1:0]      rd_cls;
    logic               a_present, b_present;

    assign in_va = s_axis_tdata[7:0];
    assign in_vb = s_axis_tdata[15:8];
    assign in_ci = s_axis_tdata[23:16];

    assign s_axis_tready = (r_state == S_IDLE) && (!r_ovalid || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign rd_valid  = ram_rdata[CW];
    assign rd_cls    = ram_rdata[CW-1:0];
    assign a_present = r_a_ok && r_ent_a[CW];
    assign b_present = r_b_ok && rd_valid;

    lbleq_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Sequencer and RAM control
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_num     = r_num;
        n_ent_a   = r_ent_a;
        n_lo      = r_lo;
        n_hi      = r_hi;
        done      = 1'b0;
        d_cls     = '0;
        d_found   = 1'b0;
        d_stat    = STAT_OK;
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = '0;
        ram_raddr = '0;

        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                ram_raddr = in_va[AW-1:0];
                if (accept) begin
                    n_state = S_RDA;
                end
            end

            // Entry of value_a is on the read port
            S_RDA: begin
                ram_raddr = r_vb[AW-1:0];
                n_ent_a   = ram_rdata;
                n_state   = S_IDLE;
                done      = 1'b1;
                case (r_func)
                    FN_ADD: begin
                        if (r_a_ok && !rd_valid) begin
                            ram_we    = 1'b1;
                            ram_waddr = r_va[AW-1:0];
                            ram_wdata = {1'b1, CW'(r_num)};
                            n_num     = r_num + 1'b1;
                        end
                    end
                    FN_MERGE: begin
                        if (r_va != r_vb) begin
                            done    = 1'b0;
                            n_state = S_RDB;
                        end
                    end
                    FN_WHICH: begin
                        if (r_a_ok && rd_valid) begin
                            d_found = 1'b1;
                            d_cls   = CLASS_W'(rd_cls);
                        end
                    end
                    default: begin
                        if ((LABEL_W + 1)'(r_ci) >= (LABEL_W + 1)'(r_num)) begin
                            d_stat = STAT_BAD_INDEX;
                        end else if (r_a_ok && rd_valid &&
                                     (CLASS_W'(rd_cls) == r_ci)) begin
                            d_found = 1'b1;
                        end
                    end
                endcase
            end

            // Entry of value_b is on the read port
            S_RDB: begin
                ram_raddr = '0;
                if (!a_present || !b_present) begin
                    d_stat  = STAT_NO_LABEL;
                    done    = 1'b1;
                    n_state = S_IDLE;
                end else if (r_ent_a[CW-1:0] == rd_cls) begin
                    done    = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_lo    = (r_ent_a[CW-1:0] < rd_cls) ? r_ent_a[CW-1:0] : rd_cls;
                    n_hi    = (r_ent_a[CW-1:0] < rd_cls) ? rd_cls : r_ent_a[CW-1:0];
                    n_addr  = '0;
                    n_state = S_SCAN;
                end
            end

            // Entry r_addr on the read port, rewrite it, read the next one
            S_SCAN: begin
                ram_raddr = r_addr + 1'b1;
                ram_waddr = r_addr;
                if (rd_valid && (rd_cls >= r_hi)) begin
                    ram_we    = 1'b1;
                    ram_wdata = {1'b1, (rd_cls == r_hi) ? r_lo : (rd_cls - 1'b1)};
                end
                n_addr = r_addr + 1'b1;
                if (r_addr == LAST) begin
                    n_addr  = '0;
                    n_num   = r_num - 1'b1;
                    done    = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_num   <= '0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_num   <= n_num;
        end
    end

    // Working payload
    always_ff @(posedge i_clk) begin
        r_ent_a <= n_ent_a;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        if (accept) begin
            r_func <= s_axis_tuser;
            r_va   <= in_va;
            r_vb   <= in_vb;
            r_ci   <= in_ci;
            r_a_ok <= ((LABEL_W + 1)'(in_va) < DEPTH_V);
            r_b_ok <= ((LABEL_W + 1)'(in_vb) < DEPTH_V);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (done) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_ocls   <= d_cls;
            r_ofound <= d_found;
            r_ostat  <= d_stat;
            r_ocount <= COUNT_W'(n_num);
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'b0000, r_ocount, r_ostat, r_ofound, r_ocls};

`ifndef SYNTHESIS
    // One item at a time: no new item right after one is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("item taken while previous one in progress");

    // Class count never exceeds the number of table entries
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (NW + 1)'(r_num) <= (NW + 1)'(DEPTH))
        else $error("class count out of range");

    // A found result always carries ok status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[8]) |-> (m_axis_tdata[10:9] == STAT_OK))
        else $error("found with error status");

    // The end of a merge sweep is followed by a result
    a_scan_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_addr == LAST) |=> (r_state == S_IDLE && m_axis_tvalid))
        else $error("merge sweep did not produce a result");
`endif

endmodule
